// ----- design/dvf_pkg.sv -----
// Shared types, constants and profile codes for the DV DIF block framer.
package dvf_pkg;

    // Fixed stream geometry.
    localparam int BlocksPerSeq   = 150;
    localparam int MaxFrameBlocks = 7200;

    // Default depths of the internal queues.
    localparam int MidDepthDef = 2;
    localparam int OutDepthDef = 2;

    // Section types taken from the top three bits of ID byte 0.
    localparam logic [2:0] SECT_HEADER  = 3'd0;
    localparam logic [2:0] SECT_SUBCODE = 3'd1;
    localparam logic [2:0] SECT_VAUX    = 3'd2;
    localparam logic [2:0] SECT_AUDIO   = 3'd3;
    localparam logic [2:0] SECT_VIDEO   = 3'd4;

    // Identifying byte values.
    localparam logic [7:0] SECT_ID_HEADER = 8'h1F;
    localparam logic [7:0] SECT_ID_VAUX_LO = 8'h50;
    localparam logic [7:0] SECT_ID_VAUX_HI = 8'h5F;
    localparam logic [7:0] PACK_HEADER_10  = 8'h3F;
    localparam logic [7:0] PACK_HEADER_12  = 8'hBF;

    // Profile codes.
    localparam logic [3:0] PROF_NONE = 4'd0;
    localparam logic [3:0] PROF_LAST = 4'd10;

    // One incoming block summary.
    typedef struct packed {
        logic [7:0] id_byte0;
        logic [7:0] id_byte1;
        logic [7:0] id_byte2;
        logic [7:0] pack_byte0;
        logic [7:0] pack_byte1;
        logic [7:0] vaux_byte48;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [12:0] write_slot;
        logic        write_valid;
        logic [12:0] fill_start;
        logic [12:0] fill_count;
        logic        frame_restart;
        logic        frame_done;
        logic [12:0] frame_length;
        logic [3:0]  profile_code;
    } out_word_t;

    // Classified block handed from the front end to the back end.
    typedef struct packed {
        logic        slot_ok;
        logic [12:0] slot;
        logic [3:0]  profile;
        logic [12:0] length;
    } class_t;

endpackage

// ----- design/dvf_queue.sv -----
// Small register queue used between the framer stages and at the output.
module dvf_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- design/dvf_front.sv -----
// Front end: profile detection and slot classification of each accepted block.
module dvf_front
    import dvf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_word_t item,
    output class_t   cls
);

    logic [3:0] prof_reg, prof_next;
    logic       seen_reg, seen_next;
    logic [2:0] dist_reg, dist_next;
    logic [2:0] apt_reg, apt_next;
    logic       twelve_reg, twelve_next;
    logic       vaux_id;
    logic       header_id;

    typedef struct packed {
        logic        ok;
        logic [12:0] slot;
    } slot_t;

    // Profile table lookup by apt, sType and the twelve-sequence flag.
    function automatic logic [3:0] profile_match(logic [2:0] apt, logic [4:0] st,
                                                 logic twelve);
        logic [3:0] r;
        r = PROF_NONE;
        if (apt == 3'd0)
        begin
            if (st == 5'h00)
            begin
                r = 4'd1;
            end
        end
        else if (apt == 3'd1)
        begin
            case (st)
                5'h00:   r = 4'd3;
                5'h04:   r = 4'd5;
                5'h14:   r = 4'd7;
                5'h18:   r = 4'd9;
                default: r = PROF_NONE;
            endcase
        end
        if (r != PROF_NONE && twelve)
        begin
            r = r + 4'd1;
        end
        return r;
    endfunction

    // Frame length in blocks for a profile code.
    function automatic logic [12:0] frame_len(logic [3:0] p);
        logic [12:0] r;
        case (p)
            4'd2, 4'd4:  r = 13'd1800;
            4'd5, 4'd9:  r = 13'd3000;
            4'd6, 4'd10: r = 13'd3600;
            4'd7:        r = 13'd6000;
            4'd8:        r = 13'd7200;
            default:     r = 13'd1500;
        endcase
        return r;
    endfunction

    // Slot of a block from its section type, sequence and block number.
    function automatic slot_t slot_of(in_word_t w);
        logic [3:0] seq;
        logic [7:0] n;
        logic [7:0] b;
        logic [3:0] q;
        slot_t      r;
        seq  = w.id_byte1[7:4];
        n    = w.id_byte2;
        b    = '0;
        q    = '0;
        r.ok = 1'b0;
        // Video blocks skip one slot after every fifteen; count the skips.
        for (int k = 1; k <= 8; k++)
        begin
            if (n >= 8'(15 * k))
            begin
                q = q + 4'd1;
            end
        end
        case (w.id_byte0[7:5])
            SECT_HEADER:
            begin
                r.ok = (n == 8'd0);
                b    = 8'd0;
            end
            SECT_SUBCODE:
            begin
                r.ok = (n < 8'd2);
                b    = 8'd1 + n;
            end
            SECT_VAUX:
            begin
                r.ok = (n < 8'd3);
                b    = 8'd3 + n;
            end
            SECT_AUDIO:
            begin
                r.ok = (n < 8'd9);
                b    = 8'd6 + {n[3:0], 4'h0};
            end
            SECT_VIDEO:
            begin
                r.ok = (n < 8'd135);
                b    = 8'd7 + n + 8'(q);
            end
            default:
            begin
                r.ok = 1'b0;
            end
        endcase
        r.slot = 13'(seq) * 13'(BlocksPerSeq) + 13'(b);
        return r;
    endfunction

    assign vaux_id   = (item.id_byte0 >= SECT_ID_VAUX_LO) && (item.id_byte0 <= SECT_ID_VAUX_HI);
    assign header_id = (item.id_byte0 == SECT_ID_HEADER) &&
                       ((item.pack_byte0 == PACK_HEADER_10) ||
                        (item.pack_byte0 == PACK_HEADER_12));

    // Header search, then VAUX check five blocks later, while no profile is known.
    always_comb
    begin
        prof_next   = prof_reg;
        seen_next   = seen_reg;
        dist_next   = dist_reg;
        apt_next    = apt_reg;
        twelve_next = twelve_reg;
        if (prof_reg == PROF_NONE)
        begin
            if (seen_reg)
            begin
                dist_next = dist_reg + 3'd1;
                if (dist_next >= 3'd5)
                begin
                    seen_next = 1'b0;
                    dist_next = 3'd0;
                    if (vaux_id)
                    begin
                        prof_next = profile_match(apt_reg, item.vaux_byte48[4:0], twelve_reg);
                    end
                end
            end
            if (prof_next == PROF_NONE && header_id)
            begin
                seen_next   = 1'b1;
                dist_next   = 3'd0;
                apt_next    = item.pack_byte1[2:0];
                twelve_next = (item.pack_byte0 == PACK_HEADER_12);
            end
        end
    end

    // Classified word for the back end.
    always_comb
    begin
        slot_t s;
        s           = slot_of(item);
        cls.slot_ok = s.ok;
        cls.slot    = s.slot;
        cls.profile = prof_next;
        cls.length  = frame_len(prof_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prof_reg   <= PROF_NONE;
            seen_reg   <= 1'b0;
            dist_reg   <= 3'd0;
            apt_reg    <= 3'd0;
            twelve_reg <= 1'b0;
        end
        else if (take)
        begin
            prof_reg   <= prof_next;
            seen_reg   <= seen_next;
            dist_reg   <= dist_next;
            apt_reg    <= apt_next;
            twelve_reg <= twelve_next;
        end
    end

endmodule

// ----- design/dvf_back.sv -----
// Back end: frame position tracking, gap fill, restart and frame end.
module dvf_back
    import dvf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        limit_we,
    input  logic [12:0] limit_wdata,
    input  logic        head_valid,
    input  class_t      cls,
    input  logic        out_full,
    output logic        fire,
    output out_word_t   res
);

    logic [12:0] limit_reg;
    logic [12:0] pos_reg, pos_next;
    logic [12:0] end_lim;
    logic [12:0] frame_end;
    logic [12:0] cur;
    logic [12:0] adv;
    logic        hit;
    logic        restart;
    logic        done;

    assign fire = head_valid && !out_full;

    // Effective frame end and slot handling for the word at the queue head.
    always_comb
    begin
        end_lim   = (limit_reg == 13'd0) ? 13'd1 : limit_reg;
        frame_end = (end_lim > cls.length) ? cls.length : end_lim;
        hit       = cls.slot_ok && (cls.slot != pos_reg) && (cls.slot < frame_end);
        restart   = hit && (cls.slot < pos_reg);
        cur       = hit ? cls.slot : pos_reg;
        adv       = cur + 13'd1;
        done      = (adv >= frame_end);
        pos_next  = done ? 13'd0 : adv;

        res.write_slot    = cur;
        res.write_valid   = 1'b1;
        res.fill_start    = (hit && !restart) ? pos_reg : 13'd0;
        res.fill_count    = !hit ? 13'd0 : (restart ? cls.slot : cls.slot - pos_reg);
        res.frame_restart = restart;
        res.frame_done    = done;
        res.frame_length  = cls.length;
        res.profile_code  = cls.profile;
    end

    // Position and buffer limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 13'd0;
            limit_reg <= 13'(MaxFrameBlocks);
        end
        else
        begin
            if (fire)
            begin
                pos_reg <= pos_next;
            end
            if (limit_we)
            begin
                limit_reg <= limit_wdata;
            end
        end
    end

endmodule

// ----- design/dv_dif_block_framer_core.sv -----
// Top level of the DV DIF block framer: front end, word queue, back end, result queue.
//
//   channel   direction  handshake          payload
//   item      in         push / full        in_word_t, one block summary per word
//   result    out        empty / pop        out_word_t, one result word per block
//   limit     in         limit_we           limit_wdata, buffer limit in blocks
//
// A word is classified in the cycle it is accepted and is written into the middle
// queue; the back end places it once it is at the head of that queue and the result
// queue has room, and writes its result into the result queue, from which it can be
// popped. One word per cycle is sustained while pop stays high.
// Reset clears the profile search, the frame position and both queues, and sets
// the buffer limit to 7200 blocks.
// When pop stays low the result queue fills, then the middle queue, and full rises.
module dv_dif_block_framer_core
    import dvf_pkg::*;
#(
    parameter int MID_DEPTH = MidDepthDef,
    parameter int OUT_DEPTH = OutDepthDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_word_t    item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output out_word_t   result,
    input  logic        limit_we,
    input  logic [12:0] limit_wdata
);

    class_t    front_cls;
    class_t    head_cls;
    out_word_t back_res;
    logic      take;
    logic      mid_empty;
    logic      back_fire;
    logic      out_full;

    assign take = push && !full;

    // Front end classifies each accepted block.
    dvf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .cls   (front_cls)
    );

    // Queue between front and back end.
    dvf_queue #(
        .W     ($bits(class_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .din   (front_cls),
        .full  (full),
        .pop   (back_fire),
        .dout  (head_cls),
        .empty (mid_empty)
    );

    // Back end places the block in the frame.
    dvf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit_we    (limit_we),
        .limit_wdata (limit_wdata),
        .head_valid  (!mid_empty),
        .cls         (head_cls),
        .out_full    (out_full),
        .fire        (back_fire),
        .res         (back_res)
    );

    // Result queue toward the consumer.
    dvf_queue #(
        .W     ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_fire),
        .din   (back_res),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

    // A restart always fills from the start of the frame.
    a_restart_fill_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_restart) |-> (result.fill_start == 13'd0))
        else $error("restart with nonzero fill start");

    // A forward gap ends right where the block is written.
    a_gap_meets_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.frame_restart && result.fill_count != 13'd0) |->
        ({1'b0, result.fill_start} + {1'b0, result.fill_count} == {1'b0, result.write_slot}))
        else $error("gap does not end at write slot");

    // Profile codes stay within the table.
    a_profile_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.profile_code <= PROF_LAST))
        else $error("profile code out of range");

endmodule

// ----- bench/dv_dif_block_framer_core_test.sv -----
// Self-checking bench for the DV DIF block framer core, driven by directed words and random DIF block streams.
module dv_dif_block_framer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dvf_pkg::*;

    localparam int DefaultFrameBlocks = 1500;
    localparam int HeaderToVaux = 5;
    localparam int SlotSpan = 16 * BlocksPerSeq;
    localparam int CycleLimit = 200000;
    localparam int PhaseCount = 9;
    localparam int PhaseWords = 125;

    // Tracks the framer state, predicts each result word and checks the words that come out.
    class framer_checker;
        int row_apt[10];
        int row_stype[10];
        int row_twelve[10];
        int row_len[10];
        int position;
        logic [3:0] profile;
        bit hdr_seen;
        int hdr_dist;
        int hdr_apt;
        bit hdr_twelve;
        int limit;
        int errors;
        out_word_t awaited_words[$];

        function new();
            row_apt = '{0, 0, 1, 1, 1, 1, 1, 1, 1, 1};
            row_stype = '{'h00, 'h00, 'h00, 'h00, 'h04, 'h04, 'h14, 'h14, 'h18, 'h18};
            row_twelve = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
            row_len = '{1500, 1800, 1500, 1800, 3000, 3600, 6000, 7200, 3000, 3600};
            position = 0;
            profile = PROF_NONE;
            hdr_seen = 0;
            hdr_dist = 0;
            hdr_apt = 0;
            hdr_twelve = 0;
            limit = MaxFrameBlocks;
            errors = 0;
        endfunction

        function int frame_len();
            return (profile == PROF_NONE) ? DefaultFrameBlocks : row_len[profile - 1];
        endfunction

        // The frame ends at the smaller of the profile length and the buffer limit.
        function int frame_end();
            int stop;
            stop = (limit == 0) ? 1 : limit;
            if (stop > frame_len())
                stop = frame_len();
            return stop;
        endfunction

        // Slot of a block inside the frame, from section type, sequence and block number.
        function bit slot_of(in_word_t w, output int slot);
            int n;
            int b;
            n = int'(w.id_byte2);
            slot = 0;
            case (w.id_byte0[7:5])
                SECT_HEADER:
                begin
                    if (n != 0) return 0;
                    b = 0;
                end
                SECT_SUBCODE:
                begin
                    if (n >= 2) return 0;
                    b = 1 + n;
                end
                SECT_VAUX:
                begin
                    if (n >= 3) return 0;
                    b = 3 + n;
                end
                SECT_AUDIO:
                begin
                    if (n >= 9) return 0;
                    b = 6 + n * 16;
                end
                SECT_VIDEO:
                begin
                    if (n >= 135) return 0;
                    b = 7 + n + n / 15;
                end
                default: return 0;
            endcase
            slot = int'(w.id_byte1[7:4]) * BlocksPerSeq + b;
            return 1;
        endfunction

        // Advance the profile search and the frame position for one accepted word.
        function void note_block(in_word_t w);
            out_word_t want;
            int slot;
            int stop;
            if (profile == PROF_NONE) begin
                if (hdr_seen) begin
                    hdr_dist++;
                    if (hdr_dist >= HeaderToVaux) begin
                        hdr_seen = 0;
                        hdr_dist = 0;
                        if (w.id_byte0 >= SECT_ID_VAUX_LO && w.id_byte0 <= SECT_ID_VAUX_HI) begin
                            for (int i = 0; i < 10; i++) begin
                                if (profile == PROF_NONE && row_apt[i] == hdr_apt &&
                                    row_stype[i] == w.vaux_byte48[4:0] &&
                                    row_twelve[i] == hdr_twelve)
                                    profile = 4'(i + 1);
                            end
                        end
                    end
                end
                if (profile == PROF_NONE && w.id_byte0 == SECT_ID_HEADER &&
                    (w.pack_byte0 == PACK_HEADER_10 || w.pack_byte0 == PACK_HEADER_12)) begin
                    hdr_seen = 1;
                    hdr_dist = 0;
                    hdr_apt = int'(w.pack_byte1[2:0]);
                    hdr_twelve = (w.pack_byte0 == PACK_HEADER_12);
                end
            end

            stop = frame_end();
            want = '0;
            want.write_valid = 1'b1;
            if (slot_of(w, slot) && slot != position && slot + 1 <= stop) begin
                if (slot < position) begin
                    want.frame_restart = 1'b1;
                    want.fill_count = 13'(slot);
                end
                else begin
                    want.fill_start = 13'(position);
                    want.fill_count = 13'(slot - position);
                end
                position = slot;
            end
            want.write_slot = 13'(position);
            position++;
            if (position >= stop) begin
                want.frame_done = 1'b1;
                position = 0;
            end
            want.frame_length = 13'(frame_len());
            want.profile_code = profile;
            awaited_words.push_back(want);
        endfunction

        function void compare_field(string name, logic [12:0] want, logic [12:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // Compare one result word with the oldest prediction.
        function void check_result(out_word_t got);
            out_word_t want;
            if (awaited_words.size() == 0) begin
                errors++;
                $display("%0t ns: result word expected none, got %h", $time, got);
                return;
            end
            want = awaited_words.pop_front();
            compare_field("write_slot", want.write_slot, got.write_slot);
            compare_field("write_valid", 13'(want.write_valid), 13'(got.write_valid));
            compare_field("fill_start", want.fill_start, got.fill_start);
            compare_field("fill_count", want.fill_count, got.fill_count);
            compare_field("frame_restart", 13'(want.frame_restart), 13'(got.frame_restart));
            compare_field("frame_done", 13'(want.frame_done), 13'(got.frame_done));
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("profile_code", 13'(want.profile_code), 13'(got.profile_code));
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic empty;
    logic pop = 1'b0;
    in_word_t item = '0;
    out_word_t result;
    logic limit_we = 1'b0;
    logic [12:0] limit_wdata = '0;

    framer_checker sb;
    int cycle_count = 0;
    int stall_pct = 0;
    logic hold_off = 1'b0;

    // Stream generator state.
    int run_slot = 0;
    int run_left = 0;
    int span = SlotSpan;
    int hdr_apt = 0;
    bit want_match = 0;
    bit allow_lock = 0;

    int phase_limit[PhaseCount] = '{7200, 150, 1, 0, 8191, 300, 7200, 2, 2400};
    int send_idle[4] = '{0, 61, 0, 38};
    int recv_idle[4] = '{0, 0, 61, 38};

    dv_dif_block_framer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .limit_we    (limit_we),
        .limit_wdata (limit_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watch both handshakes at each edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.note_block(item);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    // Receiver: random stalls plus one long hold-off.
    always @(posedge clk)
        pop <= rst_n && !hold_off && ($urandom_range(0, 99) >= stall_pct);

    // Long receiver hold-off early in the run so the block fills and backs up.
    initial
    begin
        wait (rst_n);
        repeat (40) @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("dv_dif_block_framer_core: mismatch");
            $finish;
        end
    end

    function bit stype_matches(int apt, logic [4:0] st);
        return (apt == 0 && st == 5'h00) ||
               (apt == 1 && (st == 5'h00 || st == 5'h04 || st == 5'h14 || st == 5'h18));
    endfunction

    // sType for a VAUX block: a profile hit only when the header run asked for one.
    function logic [4:0] pick_stype();
        logic [4:0] st;
        if (want_match) begin
            if (hdr_apt == 0)
                return 5'h00;
            case ($urandom_range(0, 3))
                0: st = 5'h00;
                1: st = 5'h04;
                2: st = 5'h14;
                default: st = 5'h18;
            endcase
            return st;
        end
        st = 5'($urandom_range(0, 31));
        while (stype_matches(hdr_apt, st))
            st = 5'($urandom_range(0, 31));
        return st;
    endfunction

    // Build a well-formed block for a frame slot, with random filler bytes.
    function in_word_t block_for_slot(int s);
        logic [63:0] r;
        in_word_t w;
        int seq_no;
        int b;
        int n;
        logic [2:0] kind;
        r = {$urandom(), $urandom()};
        w = r[47:0];
        seq_no = s / BlocksPerSeq;
        b = s % BlocksPerSeq;
        if (b == 0) begin
            kind = SECT_HEADER;
            n = 0;
        end
        else if (b < 3) begin
            kind = SECT_SUBCODE;
            n = b - 1;
        end
        else if (b < 6) begin
            kind = SECT_VAUX;
            n = b - 3;
        end
        else if ((b - 6) % 16 == 0) begin
            kind = SECT_AUDIO;
            n = (b - 6) / 16;
        end
        else begin
            kind = SECT_VIDEO;
            n = ((b - 7) / 16) * 15 + (b - 7) % 16;
        end
        w.id_byte0[7:5] = kind;
        w.id_byte1[7:4] = 4'(seq_no);
        w.id_byte2 = 8'(n);
        if (kind == SECT_HEADER && $urandom_range(0, 9) < 8) begin
            w.id_byte0 = SECT_ID_HEADER;
            w.pack_byte0 = $urandom_range(0, 1) ? PACK_HEADER_12 : PACK_HEADER_10;
            want_match = allow_lock && $urandom_range(0, 1);
            hdr_apt = want_match ? $urandom_range(0, 1) : $urandom_range(0, 7);
            w.pack_byte1[2:0] = 3'(hdr_apt);
        end
        if (kind == SECT_VAUX && $urandom_range(0, 9) < 9) begin
            // Section id 0x50..0x5F marks the block as VAUX for the search.
            w.id_byte0[4] = 1'b1;
            w.vaux_byte48[4:0] = pick_stype();
        end
        return w;
    endfunction

    // Mostly runs of consecutive slots with dropped blocks, some pure noise words.
    function in_word_t next_block();
        logic [63:0] r;
        if ($urandom_range(0, 99) < 12) begin
            r = {$urandom(), $urandom()};
            return r[47:0];
        end
        if (run_left == 0) begin
            run_left = $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0)
                run_slot = $urandom_range(0, SlotSpan - 1);
            else if ($urandom_range(0, 1))
                run_slot = BlocksPerSeq * $urandom_range(0, (span - 1) / BlocksPerSeq);
            else
                run_slot = $urandom_range(0, span - 1);
        end
        else if ($urandom_range(0, 19) == 0) begin
            run_slot += $urandom_range(1, 3);
        end
        if (run_slot >= SlotSpan)
            run_slot = 0;
        run_left--;
        run_slot++;
        return block_for_slot(run_slot - 1);
    endfunction

    function in_word_t blk(logic [7:0] id0, logic [7:0] id1, logic [7:0] id2,
                           logic [7:0] pk0, logic [7:0] pk1, logic [7:0] vx);
        return {id0, id1, id2, pk0, pk1, vx};
    endfunction

    // Offer one word and hold it until the block takes it.
    task automatic send_block(input in_word_t w);
        item <= w;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int idle_pct);
        for (int i = 0; i < count; i++) begin
            while ($urandom_range(0, 99) < idle_pct) begin
                push <= 1'b0;
                @(posedge clk);
            end
            send_block(next_block());
        end
        push <= 1'b0;
    endtask

    // Write the buffer limit once every outstanding word has come back.
    task automatic set_limit(input int value);
        @(posedge clk);
        while (sb.awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        limit_we <= 1'b1;
        limit_wdata <= value[12:0];
        @(posedge clk);
        limit_we <= 1'b0;
        sb.limit = value;
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: slot jumps, bad block numbers, unknown types, header search cases.
        send_block(blk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_block(blk(8'h9F, 8'h00, 8'h86, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h60, 8'h1F, 8'h08, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h1F, 8'h00, 8'h00, 8'h3F, 8'hFF, 8'h00));
        send_block(blk(8'h80, 8'h00, 8'h87, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h1F, 8'h20, 8'h00, 8'hBF, 8'h00, 8'h00));
        send_block(blk(8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h3F, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h5A, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h7F, 8'h00, 8'h09, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h55, 8'h00, 8'h02, 8'h00, 8'h00, 8'h04));
        send_block(blk(8'hA0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h80, 8'hF0, 8'h64, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h1F, 8'h00, 8'h00, 8'h3F, 8'h01, 8'h00));
        send_block(blk(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h20, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h1F, 8'h00, 8'h00, 8'hBF, 8'h00, 8'h00));
        send_block(blk(8'h40, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h40, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(blk(8'h5F, 8'h00, 8'h02, 8'h00, 8'h00, 8'hF4));
        push <= 1'b0;

        // Random phases over limit settings and idle patterns; profile lock allowed later on.
        for (int p = 0; p < PhaseCount; p++) begin
            if (p > 0)
                set_limit(phase_limit[p]);
            span = (phase_limit[p] == 0) ? 1 : phase_limit[p];
            if (span > SlotSpan)
                span = SlotSpan;
            allow_lock = (p >= 4);
            stall_pct <= recv_idle[p % 4];
            run_phase(PhaseWords, send_idle[p % 4]);
        end

        @(posedge clk);
        while (sb.awaited_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("dv_dif_block_framer_core: match");
        else
            $display("dv_dif_block_framer_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
design/dvf_pkg.sv
design/dvf_queue.sv
design/dvf_front.sv
design/dvf_back.sv
design/dv_dif_block_framer_core.sv
bench/dv_dif_block_framer_core_test.sv
